// ===== rtl/core/smb1v_pkg.sv =====
// types, command codes and check functions for the smb1 request header validator
`default_nettype none

package smb1v_pkg;

	// protocol constants
	localparam logic [31:0] SIG_WORD      = 32'h424D_53FF;
	localparam int unsigned FLAG_RESP_BIT = 7;
	localparam int unsigned FLAG2_UNI_BIT = 15;
	localparam logic [16:0] BASE_LEN      = 17'd35;

	// smb1 command numbers
	localparam logic [7:0] CMD_CREATE_DIR   = 8'h00;
	localparam logic [7:0] CMD_DELETE_DIR   = 8'h01;
	localparam logic [7:0] CMD_CLOSE        = 8'h04;
	localparam logic [7:0] CMD_FLUSH        = 8'h05;
	localparam logic [7:0] CMD_DELETE       = 8'h06;
	localparam logic [7:0] CMD_RENAME       = 8'h07;
	localparam logic [7:0] CMD_QUERY_INFO   = 8'h08;
	localparam logic [7:0] CMD_SETATTR      = 8'h09;
	localparam logic [7:0] CMD_WRITE        = 8'h0B;
	localparam logic [7:0] CMD_CHECK_DIR    = 8'h10;
	localparam logic [7:0] CMD_PROCESS_EXIT = 8'h11;
	localparam logic [7:0] CMD_LOCKING_ANDX = 8'h24;
	localparam logic [7:0] CMD_TRANS        = 8'h25;
	localparam logic [7:0] CMD_ECHO         = 8'h2B;
	localparam logic [7:0] CMD_OPEN_ANDX    = 8'h2D;
	localparam logic [7:0] CMD_READ_ANDX    = 8'h2E;
	localparam logic [7:0] CMD_WRITE_ANDX   = 8'h2F;
	localparam logic [7:0] CMD_TRANS2       = 8'h32;
	localparam logic [7:0] CMD_FIND_CLOSE2  = 8'h34;
	localparam logic [7:0] CMD_TREE_DISC    = 8'h71;
	localparam logic [7:0] CMD_NEGOTIATE    = 8'h72;
	localparam logic [7:0] CMD_SESS_SETUP   = 8'h73;
	localparam logic [7:0] CMD_LOGOFF_ANDX  = 8'h74;
	localparam logic [7:0] CMD_TREE_CONN    = 8'h75;
	localparam logic [7:0] CMD_NT_CREATE    = 8'hA2;
	localparam logic [7:0] CMD_NT_CANCEL    = 8'hA4;
	localparam logic [7:0] CMD_NT_RENAME    = 8'hA5;

	// result codes
	typedef enum logic [2:0] {
		VERDICT_ACCEPT   = 3'd0,
		VERDICT_BAD_SIG  = 3'd1,
		VERDICT_RESPONSE = 3'd2,
		VERDICT_UNSUP    = 3'd3,
		VERDICT_WC       = 3'd4,
		VERDICT_BEYOND   = 3'd5,
		VERDICT_LEN      = 3'd6
	} verdict_t;

	// outcome of the word count lookup
	typedef enum logic [1:0] {
		WC_OK    = 2'd0,
		WC_BAD   = 2'd1,
		WC_UNSUP = 2'd2
	} wc_status_t;

	// one request beat
	typedef struct packed {
		logic [31:0] signature_word;
		logic [7:0]  command_code;
		logic [7:0]  header_flags;
		logic [15:0] header_flags2;
		logic [7:0]  word_count;
		logic [15:0] byte_count;
		logic [23:0] frame_length;
		logic [15:0] data_offset;
		logic [15:0] data_count_low;
		logic [15:0] data_length_high;
	} req_t;

	// one result beat
	typedef struct packed {
		verdict_t    verdict;
		logic [16:0] expected_length;
	} res_t;

	// word count rule per command
	function automatic wc_status_t wc_check(input logic [7:0] cmd, input logic [7:0] wc);
		wc_status_t st;
		st = WC_UNSUP;
		case (cmd)
			CMD_CREATE_DIR, CMD_DELETE_DIR, CMD_QUERY_INFO, CMD_TREE_DISC,
			CMD_NEGOTIATE, CMD_NT_CANCEL, CMD_CHECK_DIR, CMD_PROCESS_EXIT: begin
				st = (wc == 8'd0) ? WC_OK : WC_BAD;
			end
			CMD_FLUSH, CMD_DELETE, CMD_RENAME, CMD_ECHO, CMD_FIND_CLOSE2: begin
				st = (wc == 8'd1) ? WC_OK : WC_BAD;
			end
			CMD_LOGOFF_ANDX: begin
				st = (wc == 8'd2) ? WC_OK : WC_BAD;
			end
			CMD_CLOSE: begin
				st = (wc == 8'd3) ? WC_OK : WC_BAD;
			end
			CMD_TREE_CONN, CMD_NT_RENAME: begin
				st = (wc == 8'd4) ? WC_OK : WC_BAD;
			end
			CMD_WRITE: begin
				st = (wc == 8'd5) ? WC_OK : WC_BAD;
			end
			CMD_SETATTR, CMD_LOCKING_ANDX: begin
				st = (wc == 8'd8) ? WC_OK : WC_BAD;
			end
			CMD_TRANS: begin
				st = (wc >= 8'd14) ? WC_OK : WC_BAD;
			end
			CMD_SESS_SETUP: begin
				st = (wc == 8'd12) ? WC_OK : WC_BAD;
			end
			CMD_OPEN_ANDX, CMD_TRANS2: begin
				st = (wc == 8'd15) ? WC_OK : WC_BAD;
			end
			CMD_NT_CREATE: begin
				st = (wc == 8'd24) ? WC_OK : WC_BAD;
			end
			CMD_READ_ANDX: begin
				st = (wc == 8'd10 || wc == 8'd12) ? WC_OK : WC_BAD;
			end
			CMD_WRITE_ANDX: begin
				st = (wc == 8'd12 || wc == 8'd14) ? WC_OK : WC_BAD;
			end
			default: begin
				st = WC_UNSUP;
			end
		endcase
		return st;
	endfunction

	// byte count rule per command (required zero or a minimum)
	function automatic logic bc_check(input logic [7:0] cmd, input logic [15:0] bc,
			input logic uni);
		logic ok;
		ok = 1'b1;
		case (cmd)
			CMD_CLOSE, CMD_FLUSH, CMD_READ_ANDX, CMD_TREE_DISC,
			CMD_LOGOFF_ANDX, CMD_NT_CANCEL, CMD_PROCESS_EXIT, CMD_FIND_CLOSE2: begin
				ok = (bc == 16'd0);
			end
			CMD_WRITE_ANDX: begin
				ok = (bc >= 16'd1);
			end
			CMD_CREATE_DIR, CMD_DELETE_DIR, CMD_DELETE, CMD_RENAME,
			CMD_QUERY_INFO, CMD_SETATTR, CMD_OPEN_ANDX, CMD_NEGOTIATE,
			CMD_CHECK_DIR: begin
				ok = (bc >= 16'd2);
			end
			CMD_TREE_CONN, CMD_WRITE: begin
				ok = (bc >= 16'd3);
			end
			CMD_NT_RENAME: begin
				ok = (bc >= 16'd4);
			end
			CMD_NT_CREATE: begin
				ok = uni ? (bc >= 16'd3) : (bc >= 16'd2);
			end
			default: begin
				ok = 1'b1;
			end
		endcase
		return ok;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/smb1v_if.sv =====
// valid/ready channel interfaces for request and result beats
`default_nettype none

interface smb1v_req_if;
	logic                valid;
	logic                ready;
	smb1v_pkg::req_t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface smb1v_res_if;
	logic                valid;
	logic                ready;
	smb1v_pkg::res_t     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/smb1_request_header_validator.sv =====
// smb1 request header validator top level
`default_nettype none

// Checks one extracted SMB1 request header per beat and returns one result
// beat: a verdict and the computed length 35 + 2*word_count + byte_count.
// Checks run in priority order: signature, response flag, supported command,
// word count, data area end within the frame, frame length match (a failed
// byte count minimum counts as a mismatch; WRITE_ANDX mismatches pass).
// A beat is registered at the input, checked in one pass of logic and
// registered again at the output, where it is offered as the result beat; a
// new request can be taken every cycle while the result side takes its beats.
// When the result side stalls, ready drops in the same cycle if both registers
// hold a beat, while an empty input register still takes one more beat first.
module smb1_request_header_validator (
	input  wire logic             clk,
	input  wire logic             arst_n,
	smb1v_req_if.sink             req,
	smb1v_res_if.source           res
);

	logic                  valid_s1;
	smb1v_pkg::req_t       data_s1;
	logic                  valid_s2;
	smb1v_pkg::res_t       data_s2;
	logic                  adv_s2;
	logic                  adv_s1;

	logic [16:0]           exp_len;
	logic [31:0]           data_end;
	smb1v_pkg::wc_status_t wc_st;
	logic                  bc_ok;
	logic                  len_bad;
	smb1v_pkg::verdict_t   verdict;

	// stage enables
	assign adv_s2    = !valid_s2 || res.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req.ready = adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req.valid) begin
			data_s1 <= req.data;
		end
	end

	// expected length
	assign exp_len = smb1v_pkg::BASE_LEN + {8'd0, data_s1.word_count, 1'b0}
		+ {1'b0, data_s1.byte_count};

	// data area end, 32-bit wrapping
	always_comb begin
		data_end = 32'd0;
		if (data_s1.command_code == smb1v_pkg::CMD_WRITE_ANDX) begin
			data_end = {data_s1.data_length_high, data_s1.data_count_low}
				+ {16'd0, data_s1.data_offset};
		end else if (data_s1.command_code == smb1v_pkg::CMD_TRANS
				|| data_s1.command_code == smb1v_pkg::CMD_TRANS2) begin
			data_end = {16'd0, data_s1.data_offset} + {16'd0, data_s1.data_count_low};
		end
	end

	// per-command table lookups
	assign wc_st   = smb1v_pkg::wc_check(data_s1.command_code, data_s1.word_count);
	assign bc_ok   = smb1v_pkg::bc_check(data_s1.command_code, data_s1.byte_count,
		data_s1.header_flags2[smb1v_pkg::FLAG2_UNI_BIT]);
	assign len_bad = !bc_ok || (data_s1.frame_length != {7'd0, exp_len});

	// verdict priority chain
	always_comb begin
		if (data_s1.signature_word != smb1v_pkg::SIG_WORD) begin
			verdict = smb1v_pkg::VERDICT_BAD_SIG;
		end else if (data_s1.header_flags[smb1v_pkg::FLAG_RESP_BIT]) begin
			verdict = smb1v_pkg::VERDICT_RESPONSE;
		end else if (wc_st == smb1v_pkg::WC_UNSUP) begin
			verdict = smb1v_pkg::VERDICT_UNSUP;
		end else if (wc_st == smb1v_pkg::WC_BAD) begin
			verdict = smb1v_pkg::VERDICT_WC;
		end else if ({8'd0, data_s1.frame_length} < data_end) begin
			verdict = smb1v_pkg::VERDICT_BEYOND;
		end else if (len_bad && data_s1.command_code != smb1v_pkg::CMD_WRITE_ANDX) begin
			verdict = smb1v_pkg::VERDICT_LEN;
		end else begin
			verdict = smb1v_pkg::VERDICT_ACCEPT;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			data_s2.verdict         <= verdict;
			data_s2.expected_length <= exp_len;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = data_s2;

`ifndef SYNTH
	// a checked beat moves into the result register
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("checked beat lost between stages");

	// both stages full and stalled means no new beat is taken
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !res.ready |-> !req.ready)
		else $error("request taken while pipeline full");

	// result register only refills from a valid check stage
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 && adv_s2 |=> !valid_s2)
		else $error("result beat without a request");

	// expected length never below the fixed header size
	a_len_floor: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> data_s2.expected_length >= smb1v_pkg::BASE_LEN)
		else $error("expected length below header size");
`endif

endmodule

`default_nettype wire
